// ===== rtl/core/brg_pkg.sv =====
// Package for the banker's resource grant block: shared widths, codes and
// the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package brg_pkg;

  localparam int TYPES          = 3;
  localparam int FIELD_W        = 8;
  localparam int CLIENT_W       = 3;
  localparam int STATUS_W       = 3;
  localparam int CLIENTS_DEF    = 5;
  localparam int UNIT_WIDTH_DEF = 8;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  localparam logic ACT_DECLARE = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  localparam logic [1:0] REG_TOTAL_A = 2'd0;
  localparam logic [1:0] REG_TOTAL_B = 2'd1;
  localparam logic [1:0] REG_TOTAL_C = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DECLARED      = 3'd0,
    ST_GRANTED       = 3'd1,
    ST_DENIED_SHORT  = 3'd2,
    ST_DENIED_UNSAFE = 3'd3,
    ST_IGNORED       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DEC_IGNORE,
    DEC_DECLARE,
    DEC_SHORT,
    DEC_TRY
  } dec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_COMMIT
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic scan_start;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    dec_t dec;
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/brg_req_if.sv =====
// Input channel of the banker's resource grant block: one beat per item.
// Depends on brg_pkg for the field widths.
`default_nettype none

interface brg_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [brg_pkg::CLIENT_W-1:0] client;
  logic [brg_pkg::FIELD_W-1:0]  amount_a;
  logic [brg_pkg::FIELD_W-1:0]  amount_b;
  logic [brg_pkg::FIELD_W-1:0]  amount_c;

  modport source (output valid, action, client, amount_a, amount_b, amount_c,
                  input ready);
  modport sink (input valid, action, client, amount_a, amount_b, amount_c,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brg_rsp_if.sv =====
// Result channel of the banker's resource grant block: one beat per item.
// Depends on brg_pkg for the field widths.
`default_nettype none

interface brg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [brg_pkg::STATUS_W-1:0] status;
  logic                         client_finished;
  logic                         all_finished;
  logic [brg_pkg::FIELD_W-1:0]  avail_a;
  logic [brg_pkg::FIELD_W-1:0]  avail_b;
  logic [brg_pkg::FIELD_W-1:0]  avail_c;

  modport source (output valid, status, client_finished, all_finished,
                  avail_a, avail_b, avail_c, input ready);
  modport sink (input valid, status, client_finished, all_finished,
                avail_a, avail_b, avail_c, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brg_ctrl.sv =====
// Controller of the banker's resource grant block: item sequencing, the
// safety scan loop and the result valid flag. Depends on brg_pkg.
`default_nettype none

module brg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  input  wire brg_pkg::sts_t sts,
  output brg_pkg::cmd_t      cmd
);

  brg_pkg::fsm_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      brg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = brg_pkg::S_DECIDE;
        end
      end
      brg_pkg::S_DECIDE: begin
        if (sts.dec == brg_pkg::DEC_TRY) begin
          cmd.scan_start = 1'b1;
          state_nxt      = brg_pkg::S_SCAN;
        end else if (out_free) begin
          cmd.decide = 1'b1;
          state_nxt  = brg_pkg::S_IDLE;
        end
      end
      brg_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = brg_pkg::S_COMMIT;
        end
      end
      brg_pkg::S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = brg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = brg_pkg::S_IDLE;
      end
    endcase
    if (cmd.decide || cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brg_dpath.sv =====
// Datapath of the banker's resource grant block: total registers, available
// and held-sum counters, the per-client held/need memory and the safety scan.
// Depends on brg_pkg; driven by brg_ctrl through cmd_t and sts_t.
`default_nettype none

module brg_dpath #(
  parameter int CLIENTS    = brg_pkg::CLIENTS_DEF,
  parameter int UNIT_WIDTH = brg_pkg::UNIT_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire brg_pkg::cmd_t                cmd,
  output brg_pkg::sts_t                     sts,
  input  wire logic                         in_action,
  input  wire logic [brg_pkg::CLIENT_W-1:0] in_client,
  input  wire logic [brg_pkg::FIELD_W-1:0]  in_amount_a,
  input  wire logic [brg_pkg::FIELD_W-1:0]  in_amount_b,
  input  wire logic [brg_pkg::FIELD_W-1:0]  in_amount_c,
  input  wire logic                         cfg_we,
  input  wire logic [brg_pkg::PADDR_W-1:0]  cfg_addr,
  input  wire logic [brg_pkg::PDATA_W-1:0]  cfg_wdata,
  output logic [brg_pkg::PDATA_W-1:0]       cfg_rdata,
  output brg_pkg::status_t                  out_status,
  output logic                              out_client_finished,
  output logic                              out_all_finished,
  output logic [brg_pkg::FIELD_W-1:0]       out_avail_a,
  output logic [brg_pkg::FIELD_W-1:0]       out_avail_b,
  output logic [brg_pkg::FIELD_W-1:0]       out_avail_c
);

  localparam int TY   = brg_pkg::TYPES;
  localparam int FW   = brg_pkg::FIELD_W;
  localparam int UW   = UNIT_WIDTH;
  localparam int CIW  = $clog2(CLIENTS);
  localparam int CNTW = $clog2(CLIENTS + 1);
  localparam int SUMW = UW + $clog2(CLIENTS);
  localparam int WW   = UW + $clog2(CLIENTS + 1);
  localparam int CMPW = (UW > FW) ? UW : FW;
  localparam logic [UW-1:0] UNIT_MAX = {UW{1'b1}};

  typedef logic [TY-1:0][UW-1:0] units_t;

  function automatic logic [UW-1:0] sat_add(input logic [UW-1:0] a,
                                            input logic [UW-1:0] b);
    logic [UW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UW] ? UNIT_MAX : s[UW-1:0];
  endfunction

  // Architectural state.
  logic [TY-1:0][FW-1:0]   tot_r, tot_nxt;
  units_t                  avail_r, avail_nxt;
  logic [TY-1:0][SUMW-1:0] hsum_r, hsum_nxt;
  logic [CLIENTS-1:0]      vld_r, done_r, done_nxt;
  logic [CNTW-1:0]         fcnt_r, fcnt_nxt;
  units_t                  mem_held [CLIENTS];
  units_t                  mem_need [CLIENTS];

  // Item and scan registers.
  logic                    act_r, cli_ok_r;
  logic [CIW-1:0]          cli_r;
  logic [TY-1:0][FW-1:0]   amt_r;
  units_t                  rd_held_r, rd_need_r, t_held_r, t_need_r;
  logic                    rd_vld_r;
  logic [TY-1:0][WW-1:0]   work_r, work_nxt;
  logic [CLIENTS-1:0]      mark_r, mark_nxt;
  logic                    prog_r, prog_any;
  logic [CIW-1:0]          ev_r, ev_nxt;

  // Result registers.
  brg_pkg::status_t        o_status_r, res_status;
  logic                    o_fin_r, res_fin, o_all_r;
  logic [TY-1:0][FW-1:0]   o_avail_r;

  logic                    in_ok, rd_en, wr_en, pass_end, fits, safe, complete;
  logic                    claim_bad, zero_req, over_need, short_av, cfg_hit;
  logic [CIW-1:0]          in_idx, rd_addr;
  logic [1:0]              cfg_t;
  units_t                  ent_held, ent_need, e_held, e_need, amt_u, eff;
  units_t                  wr_held, wr_need;
  brg_pkg::dec_t           dec;
  logic [FW-1:0]           cfg_val;
  logic [UW-1:0]           cfg_eff;

  assign in_ok    = int'(in_client) < CLIENTS;
  assign in_idx   = in_ok ? CIW'(in_client) : '0;
  assign ent_held = rd_vld_r ? rd_held_r : '0;
  assign ent_need = rd_vld_r ? rd_need_r : '0;
  assign safe     = &mark_r;
  assign complete = (t_need_r == '0);
  assign cfg_val  = cfg_wdata[FW-1:0];
  assign cfg_eff  = (CMPW'(cfg_val) > CMPW'(UNIT_MAX)) ? UNIT_MAX : UW'(cfg_val);

  always_comb begin
    cfg_hit = 1'b1;
    cfg_t   = cfg_addr[brg_pkg::PADDR_W-1:2];
    case (cfg_addr[brg_pkg::PADDR_W-1:2])
      brg_pkg::REG_TOTAL_A: cfg_t = brg_pkg::REG_TOTAL_A;
      brg_pkg::REG_TOTAL_B: cfg_t = brg_pkg::REG_TOTAL_B;
      brg_pkg::REG_TOTAL_C: cfg_t = brg_pkg::REG_TOTAL_C;
      default: begin
        cfg_hit = 1'b0;
        cfg_t   = brg_pkg::REG_TOTAL_A;
      end
    endcase
    cfg_rdata = cfg_hit ? brg_pkg::PDATA_W'(tot_r[cfg_t]) : '0;
  end

  // Item decision from the captured item and the client's entry.
  always_comb begin
    claim_bad = 1'b0;
    zero_req  = 1'b1;
    over_need = 1'b0;
    short_av  = 1'b0;
    for (int t = 0; t < TY; t++) begin
      eff[t]   = (CMPW'(tot_r[t]) > CMPW'(UNIT_MAX)) ? UNIT_MAX : UW'(tot_r[t]);
      amt_u[t] = UW'(amt_r[t]);
      if (CMPW'(amt_r[t]) > CMPW'(eff[t]))      claim_bad = 1'b1;
      if (amt_r[t] != '0)                       zero_req  = 1'b0;
      if (CMPW'(amt_r[t]) > CMPW'(ent_need[t])) over_need = 1'b1;
      if (CMPW'(amt_r[t]) > CMPW'(avail_r[t]))  short_av  = 1'b1;
    end
    if (!cli_ok_r) begin
      dec = brg_pkg::DEC_IGNORE;
    end else if (act_r == brg_pkg::ACT_DECLARE) begin
      dec = claim_bad ? brg_pkg::DEC_IGNORE : brg_pkg::DEC_DECLARE;
    end else if (zero_req || over_need) begin
      dec = brg_pkg::DEC_IGNORE;
    end else if (short_av) begin
      dec = brg_pkg::DEC_SHORT;
    end else begin
      dec = brg_pkg::DEC_TRY;
    end
  end

  // One client of the safety scan per cycle; the requesting client uses its
  // tentative entry.
  always_comb begin
    e_held   = (ev_r == cli_r) ? t_held_r : ent_held;
    e_need   = (ev_r == cli_r) ? t_need_r : ent_need;
    fits     = !mark_r[ev_r];
    for (int t = 0; t < TY; t++) begin
      if (WW'(e_need[t]) > work_r[t]) fits = 1'b0;
    end
    mark_nxt = mark_r;
    work_nxt = work_r;
    if (fits) begin
      mark_nxt[ev_r] = 1'b1;
      for (int t = 0; t < TY; t++) begin
        work_nxt[t] = work_r[t] + WW'(e_held[t]);
      end
    end
    pass_end      = (ev_r == CIW'(CLIENTS - 1));
    prog_any      = prog_r || fits;
    ev_nxt        = pass_end ? '0 : ev_r + 1'b1;
    sts.dec       = dec;
    sts.scan_done = (&mark_nxt) || (pass_end && !prog_any);
  end

  always_comb begin
    rd_en = cmd.capture || cmd.scan_start || cmd.scan_step;
    if (cmd.capture) begin
      rd_addr = in_idx;
    end else if (cmd.scan_step) begin
      rd_addr = ev_nxt;
    end else begin
      rd_addr = '0;
    end
  end

  // State updates for a finished item or a total register write.
  always_comb begin
    tot_nxt    = tot_r;
    avail_nxt  = avail_r;
    hsum_nxt   = hsum_r;
    done_nxt   = done_r;
    fcnt_nxt   = fcnt_r;
    wr_en      = 1'b0;
    wr_held    = '0;
    wr_need    = '0;
    res_status = brg_pkg::ST_IGNORED;
    res_fin    = 1'b0;
    if (cmd.decide) begin
      case (dec)
        brg_pkg::DEC_DECLARE: begin
          wr_en = 1'b1;
          for (int t = 0; t < TY; t++) begin
            avail_nxt[t] = sat_add(avail_r[t], ent_held[t]);
            hsum_nxt[t]  = hsum_r[t] - SUMW'(ent_held[t]);
            wr_need[t]   = amt_u[t];
          end
          if (done_r[cli_r]) begin
            done_nxt[cli_r] = 1'b0;
            if (fcnt_r != '0) fcnt_nxt = fcnt_r - 1'b1;
          end
          res_status = brg_pkg::ST_DECLARED;
        end
        brg_pkg::DEC_SHORT: res_status = brg_pkg::ST_DENIED_SHORT;
        default:            res_status = brg_pkg::ST_IGNORED;
      endcase
    end else if (cmd.commit) begin
      if (safe) begin
        res_status = brg_pkg::ST_GRANTED;
        wr_en      = 1'b1;
        if (complete) begin
          for (int t = 0; t < TY; t++) begin
            avail_nxt[t] = sat_add(avail_r[t] - amt_u[t], t_held_r[t]);
            hsum_nxt[t]  = hsum_r[t] + SUMW'(amt_u[t]) - SUMW'(t_held_r[t]);
          end
          if (!done_r[cli_r]) begin
            done_nxt[cli_r] = 1'b1;
            fcnt_nxt        = fcnt_r + 1'b1;
          end
          res_fin = 1'b1;
        end else begin
          wr_held = t_held_r;
          wr_need = t_need_r;
          for (int t = 0; t < TY; t++) begin
            avail_nxt[t] = avail_r[t] - amt_u[t];
            hsum_nxt[t]  = hsum_r[t] + SUMW'(amt_u[t]);
          end
        end
      end else begin
        res_status = brg_pkg::ST_DENIED_UNSAFE;
      end
    end else if (cfg_we && cfg_hit) begin
      tot_nxt[cfg_t]   = cfg_val;
      avail_nxt[cfg_t] = (hsum_r[cfg_t] >= SUMW'(cfg_eff)) ? '0 :
                         UW'(SUMW'(cfg_eff) - hsum_r[cfg_t]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r   <= '0;
      avail_r <= '0;
      hsum_r  <= '0;
      vld_r   <= '0;
      done_r  <= '0;
      fcnt_r  <= '0;
    end else begin
      tot_r   <= tot_nxt;
      avail_r <= avail_nxt;
      hsum_r  <= hsum_nxt;
      done_r  <= done_nxt;
      fcnt_r  <= fcnt_nxt;
      if (wr_en) vld_r[cli_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_held[cli_r] <= wr_held;
      mem_need[cli_r] <= wr_need;
    end
    if (rd_en) begin
      rd_held_r <= mem_held[rd_addr];
      rd_need_r <= mem_need[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_action;
      cli_ok_r <= in_ok;
      cli_r    <= in_idx;
      amt_r[0] <= in_amount_a;
      amt_r[1] <= in_amount_b;
      amt_r[2] <= in_amount_c;
    end
    if (cmd.scan_start) begin
      mark_r <= '0;
      prog_r <= 1'b0;
      ev_r   <= '0;
      for (int t = 0; t < TY; t++) begin
        t_held_r[t] <= ent_held[t] + amt_u[t];
        t_need_r[t] <= ent_need[t] - amt_u[t];
        work_r[t]   <= WW'(avail_r[t] - amt_u[t]);
      end
    end else if (cmd.scan_step) begin
      mark_r <= mark_nxt;
      work_r <= work_nxt;
      prog_r <= pass_end ? 1'b0 : prog_any;
      ev_r   <= ev_nxt;
    end
    if (cmd.decide || cmd.commit) begin
      o_status_r <= res_status;
      o_fin_r    <= res_fin;
      o_all_r    <= (fcnt_nxt == CNTW'(CLIENTS));
      for (int t = 0; t < TY; t++) begin
        o_avail_r[t] <= FW'(CMPW'(avail_nxt[t]));
      end
    end
  end

  assign out_status          = o_status_r;
  assign out_client_finished = o_fin_r;
  assign out_all_finished    = o_all_r;
  assign out_avail_a         = o_avail_r[0];
  assign out_avail_b         = o_avail_r[1];
  assign out_avail_c         = o_avail_r[2];

  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fcnt_r) <= CLIENTS)
    else $error("Finished count exceeds the number of clients.");

  a_fcnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fcnt_r) == $countones(done_r))
    else $error("Finished count disagrees with the finished flags.");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> int'(ev_r) < CLIENTS)
    else $error("Safety scan index is outside the client range.");

endmodule

`default_nettype wire

// ===== rtl/core/bankers_resource_grant_core.sv =====
// Top level of the banker's resource grant block: connects the controller,
// the datapath, the two channel interfaces and the APB-style register port.
// Depends on brg_pkg, brg_req_if, brg_rsp_if, brg_ctrl and brg_dpath.
//
// An input beat on in_ch either declares a client's maximum claim or requests
// units of the three resource types; each input beat yields one result beat
// on out_ch with a status code, completion flags and the available units.
// The totals are written through the cfg_ port (A at 0x0, B at 0x4, C at 0x8);
// the user must write them only while no item is in flight; the block itself
// does not enforce this. A write reloads that type's available count. One item
// is handled at a time. A declare, an ignored item or a short denial is decided
// in S_DECIDE once the output register is free, which registers its result and
// frees the input as the block returns to S_IDLE. A request that passes the
// checks runs the safety scan, which visits one client per cycle from the
// client memory and repeats the pass until every client is marked or a pass
// marks none, then registers its result in S_COMMIT as out_ch allows.
// The result sits in an output register, so the next item is accepted while
// a result waits; an item finishing while out_ch is stalled waits for it.
// Reset (rst_n, synchronous) clears the totals, the available counts, the
// finished flags and the entry valid bits; no clearing pass is needed.
`default_nettype none

module bankers_resource_grant_core #(
  parameter int CLIENTS    = brg_pkg::CLIENTS_DEF,
  parameter int UNIT_WIDTH = brg_pkg::UNIT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  brg_req_if.sink                          in_ch,
  brg_rsp_if.source                        out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [brg_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire logic [brg_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [brg_pkg::PDATA_W-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  brg_pkg::cmd_t    cmd;
  brg_pkg::sts_t    sts;
  brg_pkg::status_t status;
  logic             in_ready, out_valid, cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  brg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  brg_dpath #(
    .CLIENTS    (CLIENTS),
    .UNIT_WIDTH (UNIT_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_ch.action),
    .in_client           (in_ch.client),
    .in_amount_a         (in_ch.amount_a),
    .in_amount_b         (in_ch.amount_b),
    .in_amount_c         (in_ch.amount_c),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_paddr),
    .cfg_wdata           (cfg_pwdata),
    .cfg_rdata           (cfg_prdata),
    .out_status          (status),
    .out_client_finished (out_ch.client_finished),
    .out_all_finished    (out_ch.all_finished),
    .out_avail_a         (out_ch.avail_a),
    .out_avail_b         (out_ch.avail_b),
    .out_avail_c         (out_ch.avail_c)
  );

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.status = status;

endmodule

`default_nettype wire
